// ----- rtl/mts_pkg.sv -----
package mts_pkg;

	localparam int DEF_STACK_DEPTH = 256;
	localparam int DEF_VALUE_WIDTH = 32;

	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic       push;     // write value on both stores as needed
		logic       pop;      // drop top, start read of the new top
		logic       take;     // record status of the accepted transaction
		logic [1:0] status;
		logic       capture;  // load read data into top and min registers
		logic       load_out; // copy current result into the output register
	} ctl_t;

	// status from datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
	} sts_t;

endpackage

// ----- rtl/mts_ctrl.sv -----
module mts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      cmd,
	output logic            out_valid,
	input  logic            out_ready,
	input  mts_pkg::sts_t   sts,
	output mts_pkg::ctl_t   ctl
);
	import mts_pkg::*;

	localparam logic S_IDLE  = 1'b0;
	localparam logic S_FETCH = 1'b1;

	logic state_q;
	logic pending_q;
	logic out_valid_q;
	logic load_out;
	logic accept;
	logic do_push;
	logic do_pop;

	assign load_out = pending_q && (!out_valid_q || out_ready);
	assign in_ready = (state_q == S_IDLE) && (!pending_q || load_out);
	assign accept   = in_valid && in_ready;
	assign do_push  = accept && (cmd == CMD_PUSH) && !sts.full;
	assign do_pop   = accept && (cmd == CMD_POP) && !sts.empty;

	always_comb begin
		ctl          = '0;
		ctl.push     = do_push;
		ctl.pop      = do_pop;
		ctl.take     = accept;
		ctl.capture  = (state_q == S_FETCH);
		ctl.load_out = load_out;
		case (cmd)
			CMD_PUSH: ctl.status = sts.full ? ST_FULL : ST_OK;
			CMD_POP:  ctl.status = sts.empty ? ST_EMPTY : ST_OK;
			default:  ctl.status = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE:  state_q <= do_pop ? S_FETCH : S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			// a pop result is ready only once the read data is captured
			if ((accept && !do_pop) || state_q == S_FETCH)
				pending_q <= 1'b1;
			else if (load_out)
				pending_q <= 1'b0;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/mts_dpath.sv -----
module mts_dpath #(
	parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = mts_pkg::DEF_VALUE_WIDTH
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  mts_pkg::ctl_t                            ctl,
	output mts_pkg::sts_t                            sts,
	input  logic signed [VALUE_WIDTH-1:0]            value,
	output logic signed [VALUE_WIDTH-1:0]            top_value,
	output logic signed [VALUE_WIDTH-1:0]            min_value,
	output logic                                     is_empty,
	output logic [$clog2(STACK_DEPTH+1)-1:0]         entry_count,
	output logic [1:0]                               status
);
	import mts_pkg::*;

	localparam int IDX_W   = $clog2(STACK_DEPTH);
	localparam int COUNT_W = $clog2(STACK_DEPTH + 1);

	logic signed [VALUE_WIDTH-1:0] vmem [STACK_DEPTH];
	logic signed [VALUE_WIDTH-1:0] mmem [STACK_DEPTH];

	logic [COUNT_W-1:0]            count_q;
	logic [COUNT_W-1:0]            mcount_q;
	logic signed [VALUE_WIDTH-1:0] top_q;
	logic signed [VALUE_WIDTH-1:0] min_q;
	logic [1:0]                    status_q;
	logic signed [VALUE_WIDTH-1:0] vrd_q;
	logic signed [VALUE_WIDTH-1:0] mrd_q;

	logic               min_push;
	logic               min_drop;
	logic [COUNT_W-1:0] mcount_nx;
	logic [COUNT_W-1:0] vra;
	logic [COUNT_W-1:0] mra;

	assign min_push  = (mcount_q == '0) || (value <= min_q);
	assign min_drop  = (mcount_q != '0) && (top_q == min_q);
	assign mcount_nx = mcount_q - {{(COUNT_W-1){1'b0}}, min_drop};
	// address the entries that become the tops after a pop
	assign vra       = count_q - COUNT_W'(2);
	assign mra       = mcount_nx - COUNT_W'(1);

	assign sts.full  = (count_q == COUNT_W'(STACK_DEPTH));
	assign sts.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			vmem[count_q[IDX_W-1:0]] <= value;
			if (min_push)
				mmem[mcount_q[IDX_W-1:0]] <= value;
		end
		vrd_q <= vmem[vra[IDX_W-1:0]];
		mrd_q <= mmem[mra[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			mcount_q <= '0;
			top_q    <= '0;
			min_q    <= '0;
			status_q <= ST_OK;
		end else begin
			if (ctl.push) begin
				count_q <= count_q + COUNT_W'(1);
				top_q   <= value;
				if (min_push) begin
					mcount_q <= mcount_q + COUNT_W'(1);
					min_q    <= value;
				end
			end
			if (ctl.pop) begin
				count_q  <= count_q - COUNT_W'(1);
				mcount_q <= mcount_nx;
			end
			if (ctl.capture) begin
				top_q <= (count_q == '0) ? '0 : vrd_q;
				min_q <= (count_q == '0) ? '0 : mrd_q;
			end
			if (ctl.take)
				status_q <= ctl.status;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			top_value   <= top_q;
			min_value   <= min_q;
			is_empty    <= (count_q == '0);
			entry_count <= count_q;
			status      <= status_q;
		end
	end

endmodule

// ----- rtl/min_tracking_stack_top.sv -----
// channel  | handshake            | payload
// input    | in_valid / in_ready  | cmd, value
// output   | out_valid / out_ready| top_value, min_value, is_empty, entry_count, status
//
// A pop moves the controller into a fetch state, in which input stalls, as the new top
// and minimum come from a registered read of the two stores; push, read and refused
// transactions need none. Results wait pending until the output register is free.
// One further transaction is taken while a result waits; then input stalls.
// Reset clears the counts; store contents stay undefined and are never read unwritten.
module min_tracking_stack_top #(
	parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = mts_pkg::DEF_VALUE_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           cmd,
	input  logic signed [VALUE_WIDTH-1:0]        value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [VALUE_WIDTH-1:0]        top_value,
	output logic signed [VALUE_WIDTH-1:0]        min_value,
	output logic                                 is_empty,
	output logic [$clog2(STACK_DEPTH+1)-1:0]     entry_count,
	output logic [1:0]                           status
);
	import mts_pkg::*;

	localparam int COUNT_W = $clog2(STACK_DEPTH + 1);

	ctl_t ctl;
	sts_t sts;

	mts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	mts_dpath #(
		.STACK_DEPTH (STACK_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.value       (value),
		.top_value   (top_value),
		.min_value   (min_value),
		.is_empty    (is_empty),
		.entry_count (entry_count),
		.status      (status)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= COUNT_W'(STACK_DEPTH))
		else $error("entry count beyond depth");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> top_value == '0 && min_value == '0 && entry_count == '0)
		else $error("empty result carries non-zero fields");

	a_min_le_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_empty |-> min_value <= top_value)
		else $error("minimum above top");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == COUNT_W'(STACK_DEPTH))
		else $error("full refusal while not full");

	a_pop_capture: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |=> ctl.capture && !in_ready)
		else $error("pop not followed by capture");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import mts_pkg::*;

	localparam int DEPTH = mts_pkg::DEF_STACK_DEPTH;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 20;
	localparam int LONG_HOLD = 80;
	localparam int PRINT_CAP = 40;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	typedef struct packed {
		logic [31:0] top;
		logic [31:0] least;
		logic        empty;
		logic [8:0]  count;
		logic [1:0]  st;
	} stack_view_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] operand;
		logic        typed;
		stack_view_t view;
	} script_row_t;

	typedef enum logic [1:0] {MIX_PUSHY, MIX_POPPY, MIX_EVEN} mix_t;
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = CMD_READ;
	logic signed [31:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] top_value;
	logic signed [31:0] min_value;
	logic is_empty;
	logic [8:0] entry_count;
	logic [1:0] status;

	// stack contents as they should be, updated on every accepted transaction
	logic [31:0] held_vals [DEPTH];
	logic [31:0] held_mins [DEPTH];
	int held = 0;
	int held_min = 0;

	stack_view_t pending_views [$];
	script_row_t script [$];

	logic row_typed = 1'b0;
	stack_view_t row_view = '0;

	int cycles = 0;
	int errors = 0;
	int accepted = 0;
	int results = 0;
	int pushes = 0;
	int pops = 0;
	int full_refusals = 0;
	int empty_refusals = 0;
	int peak = 0;
	int burst_left = 0;
	int hold_requests = 0;

	always #1 clk = ~clk;

	min_tracking_stack_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.top_value(top_value),
		.min_value(min_value),
		.is_empty(is_empty),
		.entry_count(entry_count),
		.status(status)
	);

	function automatic stack_view_t advance_stack(input logic [1:0] op, input logic [31:0] operand);
		stack_view_t v;
		v.st = ST_OK;
		if (op == CMD_PUSH) begin
			if (held >= DEPTH) begin
				v.st = ST_FULL;
				full_refusals++;
			end else begin
				held_vals[held] = operand;
				held++;
				// equal values go on the min store again so duplicates survive pops
				if (held_min == 0 || $signed(operand) <= $signed(held_mins[held_min - 1])) begin
					held_mins[held_min] = operand;
					held_min++;
				end
				pushes++;
			end
		end else if (op == CMD_POP) begin
			if (held == 0) begin
				v.st = ST_EMPTY;
				empty_refusals++;
			end else begin
				if (held_min > 0 && held_vals[held - 1] == held_mins[held_min - 1])
					held_min--;
				held--;
				pops++;
			end
		end
		v.top = (held > 0) ? held_vals[held - 1] : '0;
		v.least = (held > 0 && held_min > 0) ? held_mins[held_min - 1] : '0;
		v.empty = (held == 0);
		v.count = 9'(held);
		if (held > peak)
			peak = held;
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= PRINT_CAP)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic row(input logic [1:0] op, input logic [31:0] operand, input logic typed,
			input logic [31:0] top, input logic [31:0] least, input logic empty,
			input int count, input logic [1:0] st);
		script_row_t r;
		r.op = op;
		r.operand = operand;
		r.typed = typed;
		r.view.top = top;
		r.view.least = least;
		r.view.empty = empty;
		r.view.count = 9'(count);
		r.view.st = st;
		script = {script, r};
	endtask

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return $urandom_range(0, 15) - 8;
		if (r == 4) begin
			case ($urandom_range(0, 3))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
		return $urandom;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic offer(input logic [1:0] op, input logic [31:0] operand, input logic typed,
			input stack_view_t view);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		cmd = op;
		value = operand;
		row_typed = typed;
		row_view = view;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic mixed_run(input int n);
		mix_t m;
		int seg;
		int r;
		int p_push;
		int p_pop;
		logic [1:0] op;
		seg = 0;
		m = MIX_EVEN;
		repeat (n) begin
			if (seg == 0) begin
				m = mix_t'($urandom_range(0, 2));
				seg = $urandom_range(5, 25);
			end
			seg--;
			p_push = (m == MIX_PUSHY) ? 70 : (m == MIX_POPPY) ? 25 : 45;
			p_pop = (m == MIX_POPPY) ? 65 : (m == MIX_PUSHY) ? 20 : 45;
			r = $urandom_range(0, 99);
			if (r < p_push)
				op = CMD_PUSH;
			else if (r < p_push + p_pop)
				op = CMD_POP;
			else if (r < 97)
				op = CMD_READ;
			else
				op = CMD_SPARE;
			offer(op, pick_value(), 1'b0, '0);
		end
	endtask

	// the predictor always advances; rows with a typed expectation override its view
	task automatic row_view_take();
		stack_view_t v;
		v = advance_stack(cmd, value);
		if (row_typed)
			v = row_view;
		pending_views = {pending_views, v};
	endtask

	task automatic check_result(input stack_view_t want);
		if (top_value !== want.top)
			report_mismatch($sformatf("result %0d top_value %0d, expected %0d", results,
				top_value, $signed(want.top)));
		if (min_value !== want.least)
			report_mismatch($sformatf("result %0d min_value %0d, expected %0d", results,
				min_value, $signed(want.least)));
		if (is_empty !== want.empty)
			report_mismatch($sformatf("result %0d is_empty %b, expected %b", results,
				is_empty, want.empty));
		if (entry_count !== want.count)
			report_mismatch($sformatf("result %0d entry_count %0d, expected %0d", results,
				entry_count, want.count));
		if (status !== want.st)
			report_mismatch($sformatf("result %0d status %0d, expected %0d", results,
				status, want.st));
	endtask

	always @(posedge clk) begin
		cycles++;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				row_view_take();
				accepted++;
			end
			if (out_valid && out_ready) begin
				results++;
				if (pending_views.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing expected",
						results));
				end else begin
					check_result(pending_views.pop_front());
				end
			end
		end
	end

	// receiver: changing stall patterns, plus one long hold-off on request
	initial begin
		rx_mode_t mode;
		int phase_left;
		int hold_left;
		int holds_served;
		mode = RX_OPEN;
		phase_left = 0;
		hold_left = 0;
		holds_served = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				if (phase_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					phase_left = $urandom_range(10, 60);
				end
				phase_left--;
				case (mode)
					RX_OPEN: out_ready = 1'b1;
					RX_COIN: out_ready = 1'($urandom_range(0, 1));
					default: out_ready = (phase_left % 4) != 0;
				endcase
			end
		end
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycles,
			pending_views.size());
		$display("simulation failed");
		$finish;
	end

	initial begin
		int run_val;
		int base;
		int r;
		row(CMD_READ,  32'h0000_0000, 1'b1, 32'h0, 32'h0, 1'b1, 0, ST_OK);
		row(CMD_POP,   32'h0000_0000, 1'b1, 32'h0, 32'h0, 1'b1, 0, ST_EMPTY);
		row(CMD_SPARE, 32'hffff_ffff, 1'b1, 32'h0, 32'h0, 1'b1, 0, ST_OK);
		row(CMD_PUSH,  32'd5,         1'b1, 32'd5, 32'd5, 1'b0, 1, ST_OK);
		row(CMD_PUSH,  32'h7fff_ffff, 1'b1, 32'h7fff_ffff, 32'd5, 1'b0, 2, ST_OK);
		row(CMD_PUSH,  32'h8000_0000, 1'b1, 32'h8000_0000, 32'h8000_0000, 1'b0, 3, ST_OK);
		row(CMD_PUSH,  32'h8000_0000, 1'b1, 32'h8000_0000, 32'h8000_0000, 1'b0, 4, ST_OK);
		row(CMD_POP,   32'hffff_ffff, 1'b1, 32'h8000_0000, 32'h8000_0000, 1'b0, 3, ST_OK);
		row(CMD_POP,   32'h0000_0000, 1'b1, 32'h7fff_ffff, 32'd5, 1'b0, 2, ST_OK);
		row(CMD_SPARE, 32'h1234_5678, 1'b1, 32'h7fff_ffff, 32'd5, 1'b0, 2, ST_OK);
		row(CMD_READ,  32'h8000_0000, 1'b0, '0, '0, 1'b0, 0, ST_OK);
		row(CMD_PUSH,  32'd5,         1'b0, '0, '0, 1'b0, 0, ST_OK);
		row(CMD_PUSH,  32'hffff_ffff, 1'b0, '0, '0, 1'b0, 0, ST_OK);
		row(CMD_PUSH,  32'd3,         1'b0, '0, '0, 1'b0, 0, ST_OK);
		row(CMD_PUSH,  32'hffff_ffff, 1'b0, '0, '0, 1'b0, 0, ST_OK);
		repeat (6)
			row(CMD_POP, 32'h0, 1'b0, '0, '0, 1'b0, 0, ST_OK);
		row(CMD_POP,   32'h0000_0000, 1'b1, 32'h0, 32'h0, 1'b1, 0, ST_EMPTY);
		row(CMD_PUSH,  32'h0000_0000, 1'b1, 32'h0, 32'h0, 1'b0, 1, ST_OK);
		row(CMD_POP,   32'h0000_0000, 1'b1, 32'h0, 32'h0, 1'b1, 0, ST_OK);

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (script[i])
			offer(script[i].op, script[i].operand, script[i].typed, script[i].view);

		mixed_run(10);

		// fill to the top, mostly non-increasing so the min store runs deep;
		// the receiver holds off at the start so the block backs up
		hold_requests++;
		base = full_refusals;
		run_val = $urandom_range(0, 32'h3fff_ffff);
		while (held < DEPTH || full_refusals - base < 5) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				offer(CMD_READ, $urandom, 1'b0, '0);
			end else if (r < 3) begin
				offer(CMD_PUSH, pick_value(), 1'b0, '0);
			end else begin
				run_val = run_val - $urandom_range(0, 1);
				offer(CMD_PUSH, run_val, 1'b0, '0);
			end
		end

		// drain past empty
		base = empty_refusals;
		while (held > 0 || empty_refusals - base < 5) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				offer(($urandom_range(0, 1) != 0) ? CMD_READ : CMD_SPARE, $urandom, 1'b0, '0);
			else if (r < 3)
				offer(CMD_PUSH, pick_value(), 1'b0, '0);
			else
				offer(CMD_POP, $urandom, 1'b0, '0);
		end

		mixed_run(10);
		in_valid = 1'b0;

		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d transactions, %0d results: %0d pushes, %0d pops,", accepted, results,
			pushes, pops);
		$display("%0d full and %0d empty refusals; stack peaked at %0d entries and was drained",
			full_refusals, empty_refusals, peak);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
